>>> rtl/core/pmgd_pkg.sv
// Package for the point-mass gravity derivative core.
// Holds field widths, the fixed-point scaling, reset values and the side-data type.
// No dependencies.
package pmgd_pkg;

    // Default and largest coordinate width in bits.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int COORD_WIDTH_MAX = 48;

    // Fixed field widths.
    localparam int POS_W = 32;
    localparam int VEL_W = 32;
    localparam int ACC_W = 48;
    localparam int GP_W  = 50;

    // Acceleration is scaled by 2^FRAC_W.
    localparam int FRAC_W = 32;
    // Quotient bits kept by the divider (one above the acceleration range).
    localparam int QUOT_W = ACC_W + 1;
    // Partial-product chunk of the multipliers.
    localparam int MUL_CHUNK = 32;

    localparam logic [GP_W-1:0] GP_RESET = GP_W'(64'd398600441800000);

    localparam logic [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_NEG_MAX = {1'b1, {(ACC_W-1){1'b0}}};

    // Data that travels beside the arithmetic.
    typedef struct packed {
        logic [2:0][VEL_W-1:0] vel;
        logic [2:0]            neg;
        logic                  zero;
    } t_side;

endpackage

>>> rtl/core/pmgd_mul.sv
// Two-stage unsigned multiplier built from 32 by 32 partial products.
// Uses pmgd_pkg for the chunk size.
module pmgd_mul
    import pmgd_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PW = (NA + NB) * MUL_CHUNK;

    logic [NA*MUL_CHUNK-1:0]   a_pad;
    logic [NB*MUL_CHUNK-1:0]   b_pad;
    logic [2*MUL_CHUNK-1:0]    r_pp [NA*NB];
    logic [PW-1:0]             n_sum;
    logic [AW+BW-1:0]          r_p;

    assign a_pad = (NA*MUL_CHUNK)'(i_a);
    assign b_pad = (NB*MUL_CHUNK)'(i_b);

    // First stage: the partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= (2*MUL_CHUNK)'(a_pad[i*MUL_CHUNK +: MUL_CHUNK])
                                  * (2*MUL_CHUNK)'(b_pad[j*MUL_CHUNK +: MUL_CHUNK]);
                end
            end
        end
    end

    // Second stage: shift and add the partial products.
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (PW'(r_pp[i*NB+j]) << ((i + j) * MUL_CHUNK));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_sum[AW+BW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/pmgd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Computes floor(prod * 2^FRAC_W / den) and flags a quotient too wide to keep.
// Uses pmgd_pkg for the quotient and scaling widths.
module pmgd_div
    import pmgd_pkg::*;
#(
    parameter int NW = 82,
    parameter int DW = 96
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NW-1:0]     i_prod,
    input  logic [DW-1:0]     i_den,
    output logic [QUOT_W-1:0] o_quot,
    output logic              o_big
);

    localparam int XW = NW + FRAC_W;
    localparam int HW = XW - QUOT_W;
    localparam int CW = DW + XW;

    logic [XW-1:0]     num;
    logic [HW-1:0]     num_hi;
    logic              init_big;

    logic [DW-1:0]     r_rem  [QUOT_W+1];
    logic [DW-1:0]     r_den  [QUOT_W+1];
    logic [QUOT_W-1:0] r_low  [QUOT_W+1];
    logic [QUOT_W-1:0] r_q    [QUOT_W+1];
    logic              r_big  [QUOT_W+1];

    assign num      = {i_prod, {FRAC_W{1'b0}}};
    assign num_hi   = num[XW-1:QUOT_W];
    assign init_big = CW'(num_hi) >= CW'(i_den);

    // Entry stage: the upper part of the numerator must stay below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(num_hi);
            r_den[0] <= i_den;
            r_low[0] <= num[QUOT_W-1:0];
            r_q[0]   <= '0;
            r_big[0] <= init_big;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 1; j <= QUOT_W; j++) begin : g_step
        logic [DW:0]   rem_sh;
        logic [DW:0]   rem_sub;
        logic          take;

        assign rem_sh  = {r_rem[j-1], r_low[j-1][QUOT_W-j]};
        assign rem_sub = rem_sh - {1'b0, r_den[j-1]};
        assign take    = rem_sh >= {1'b0, r_den[j-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_den[j] <= r_den[j-1];
                r_low[j] <= r_low[j-1];
                r_q[j]   <= r_q[j-1] | (QUOT_W'(take) << (QUOT_W - j));
                r_big[j] <= r_big[j-1];
            end
        end
    end

    assign o_quot = r_q[QUOT_W];
    assign o_big  = r_big[QUOT_W];

endmodule

>>> rtl/core/point_mass_gravity_derivative_core.sv
// Point-mass gravity derivative core: the top level.
// Uses pmgd_pkg, pmgd_mul and pmgd_div.
//
// For each orbital state item (position in metres, velocity in mm/s) the core returns
// the velocity unchanged and the acceleration -mu * r / |r|^3 in units of 2^-32 m/s^2,
// truncated toward zero, saturated to 48 bits with o_fault raised; a zero radius gives
// zero acceleration with o_fault raised. The core takes one item every cycle while the
// output item is not stalled. One bit per stage in the square-root chain (COORD_WIDTH
// stages) and in the three dividers (49 stages each) makes up most of the pipeline.
// The whole pipeline holds while the output item is stalled. The gravitational
// parameter must be written through the configuration port only while no item is in
// flight; the core itself does not enforce this.
module point_mass_gravity_derivative_core
    import pmgd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [GP_W-1:0]         i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [VEL_W-1:0] i_vel_x,
    input  logic signed [VEL_W-1:0] i_vel_y,
    input  logic signed [VEL_W-1:0] i_vel_z,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VEL_W-1:0] o_dpos_x,
    output logic signed [VEL_W-1:0] o_dpos_y,
    output logic signed [VEL_W-1:0] o_dpos_z,
    output logic signed [ACC_W-1:0] o_accel_x,
    output logic signed [ACC_W-1:0] o_accel_y,
    output logic signed [ACC_W-1:0] o_accel_z,
    output logic                    o_fault
);

    localparam int W      = COORD_WIDTH;
    localparam int R2_W   = 2 * W;
    localparam int DEN_W  = 3 * W;
    localparam int PROD_W = GP_W + W;
    localparam int PROD_N = W + 3;
    localparam int SIDE_N = 56 + W;
    localparam int LAT    = 57 + W;

    logic en;

    logic [GP_W-1:0] r_grav;

    logic [LAT-1:0]  r_vld;
    t_side           r_side [SIDE_N];

    logic [COORD_WIDTH_MAX-1:0] raw  [3];
    logic [W-1:0]               cval [3];
    logic [2:0]                 n_neg;
    logic [W-1:0]               n_mag [3];
    logic [W-1:0]               r_mag [3];

    logic [R2_W-1:0]   sq   [3];
    logic [PROD_W-1:0] prod [3];
    logic [PROD_W-1:0] r_prod [PROD_N][3];

    logic [R2_W-1:0] r_sq_rem [W+1];
    logic [W-1:0]    r_sq_s   [W+1];
    logic [R2_W-1:0] r_sq_r2  [W+1];

    logic [DEN_W-1:0]  den;
    logic [QUOT_W-1:0] quot [3];
    logic              big  [3];

    logic [ACC_W-1:0] n_acc [3];
    logic             n_fault;
    logic [ACC_W-1:0] r_acc [3];
    logic             r_fault;
    logic [2:0][VEL_W-1:0] r_dpos;

    // The pipeline moves unless the output item is waiting.
    assign en          = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GP_RESET;
        end else if (i_cfg_valid) begin
            r_grav <= i_cfg_data;
        end
    end

    // Valid bits travel beside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Coordinates: low W bits, sign taken from bit W-1, split into sign and magnitude.
    assign raw[0] = COORD_WIDTH_MAX'(unsigned'(i_pos_x));
    assign raw[1] = COORD_WIDTH_MAX'(unsigned'(i_pos_y));
    assign raw[2] = COORD_WIDTH_MAX'(unsigned'(i_pos_z));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cval[i]  = raw[i][W-1:0];
            n_neg[i] = cval[i][W-1];
            n_mag[i] = n_neg[i] ? (~cval[i] + W'(1)) : cval[i];
        end
    end

    // Entry stage and the side-data delay line.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= n_mag[i];
            end
            r_side[0].vel  <= {i_vel_z, i_vel_y, i_vel_x};
            r_side[0].neg  <= n_neg;
            r_side[0].zero <= (n_mag[0] == '0) && (n_mag[1] == '0) && (n_mag[2] == '0);
            for (int k = 1; k < SIDE_N; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Squares of the magnitudes and mu times each magnitude.
    for (genvar i = 0; i < 3; i++) begin : g_axis_mul
        pmgd_mul #(.AW(W), .BW(W)) u_sq (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_mag[i]),
            .i_b   (r_mag[i]),
            .o_p   (sq[i])
        );

        pmgd_mul #(.AW(GP_W), .BW(W)) u_prod (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_grav),
            .i_b   (r_mag[i]),
            .o_p   (prod[i])
        );
    end

    // The numerator products wait for the denominator.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod[0] <= prod;
            for (int k = 1; k < PROD_N; k++) begin
                r_prod[k] <= r_prod[k-1];
            end
        end
    end

    // Squared radius; it enters the square-root chain.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0] <= sq[0] + sq[1] + sq[2];
            r_sq_r2[0]  <= sq[0] + sq[1] + sq[2];
            r_sq_s[0]   <= '0;
        end
    end

    // Integer square root, one result bit per stage; rem holds r2 - s^2.
    for (genvar k = 0; k < W; k++) begin : g_sqrt
        localparam int B = W - 1 - k;
        logic [R2_W:0] trial;
        logic          take;

        assign trial = ((R2_W+1)'(r_sq_s[k]) << (B + 1)) | ((R2_W+1)'(1) << (2 * B));
        assign take  = {1'b0, r_sq_rem[k]} >= trial;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k+1] <= take ? R2_W'({1'b0, r_sq_rem[k]} - trial) : r_sq_rem[k];
                r_sq_s[k+1]   <= r_sq_s[k] | (W'(take) << B);
                r_sq_r2[k+1]  <= r_sq_r2[k];
            end
        end
    end

    // Denominator r2 * floor(sqrt(r2)).
    pmgd_mul #(.AW(R2_W), .BW(W)) u_den (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_sq_r2[W]),
        .i_b   (r_sq_s[W]),
        .o_p   (den)
    );

    // One divider per axis.
    for (genvar i = 0; i < 3; i++) begin : g_axis_div
        pmgd_div #(.NW(PROD_W), .DW(DEN_W)) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_prod (r_prod[PROD_N-1][i]),
            .i_den  (den),
            .o_quot (quot[i]),
            .o_big  (big[i])
        );
    end

    // Sign, saturation and the zero-radius case.
    always_comb begin
        n_fault = r_side[SIDE_N-1].zero;
        for (int i = 0; i < 3; i++) begin
            if (r_side[SIDE_N-1].zero) begin
                n_acc[i] = '0;
            end else if (r_side[SIDE_N-1].neg[i]) begin
                if (big[i] || (quot[i] > QUOT_W'(ACC_POS_MAX))) begin
                    n_acc[i] = ACC_POS_MAX;
                    n_fault  = 1'b1;
                end else begin
                    n_acc[i] = quot[i][ACC_W-1:0];
                end
            end else begin
                if (big[i] || (quot[i] > QUOT_W'(ACC_NEG_MAX))) begin
                    n_acc[i] = ACC_NEG_MAX;
                    n_fault  = 1'b1;
                end else begin
                    n_acc[i] = ACC_W'(~quot[i] + QUOT_W'(1));
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_acc   <= n_acc;
            r_fault <= n_fault;
            r_dpos  <= r_side[SIDE_N-1].vel;
        end
    end

    assign o_out_valid = r_vld[LAT-1];
    assign o_dpos_x    = signed'(r_dpos[0]);
    assign o_dpos_y    = signed'(r_dpos[1]);
    assign o_dpos_z    = signed'(r_dpos[2]);
    assign o_accel_x   = signed'(r_acc[0]);
    assign o_accel_y   = signed'(r_acc[1]);
    assign o_accel_z   = signed'(r_acc[2]);
    assign o_fault     = r_fault;

    // A held pipeline keeps every valid bit of the chain where it is.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid chain moved while the pipeline was held");

    // An accepted item enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    // A zero radius leaves with zero acceleration and a fault.
    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-2] && r_side[SIDE_N-1].zero && en) |=>
        (o_fault && (o_accel_x == '0) && (o_accel_y == '0) && (o_accel_z == '0)))
        else $error("zero radius did not give a faulted zero result");

endmodule
